@@ src/sbd_pkg.sv @@
// Package: types and constants shared by the signed binary to decimal digit unit.
`timescale 1ns / 1ps

package sbd_pkg;

    // Input value port width. The parameter VALUE_BITS on the top level picks how many low
    // bits of it take part in the conversion.
    localparam int VALUE_W = 64;
    localparam int DIGIT_W = 4;

    // Width mode codes
    localparam logic [1:0] MODE_INT   = 2'd0;
    localparam logic [1:0] MODE_CHAR  = 2'd1;
    localparam logic [1:0] MODE_SHORT = 2'd2;
    localparam logic [1:0] MODE_LONG  = 2'd3;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [1:0]                width_mode;
        logic                      zero_precision;
    } sbd_in_t;

    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic               negative;
        logic               empty_res;
        logic               last;
    } sbd_out_t;

    // Per-cycle command broadcast to every digit cell
    typedef struct packed {
        logic clear;   // zero the digit
        logic dabble;  // add-3 correction and shift one binary bit in
        logic move;    // shift whole digits one cell toward the top
    } sbd_cell_ctrl_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_SKIP,
        S_EMIT
    } sbd_state_t;

endpackage

@@ src/sbd_digit_cell.sv @@
// One BCD digit cell of the double-dabble chain.
`timescale 1ns / 1ps

module sbd_digit_cell (
    input  logic                        aclk,
    input  sbd_pkg::sbd_cell_ctrl_t     ctrl,
    input  logic                        carry_in,   // binary bit from the lower cell
    input  logic [sbd_pkg::DIGIT_W-1:0] digit_in,   // lower cell's digit, for digit moves
    output logic                        carry_out,
    output logic [sbd_pkg::DIGIT_W-1:0] digit
);

    logic [sbd_pkg::DIGIT_W-1:0] digit_reg;
    logic [sbd_pkg::DIGIT_W-1:0] digit_next;
    logic [sbd_pkg::DIGIT_W-1:0] adj;

    // add 3 when the digit would overflow past 9 after doubling
    assign adj = (digit_reg >= sbd_pkg::DIGIT_W'(5)) ?
                 (digit_reg + sbd_pkg::DIGIT_W'(3)) : digit_reg;

    always_comb begin
        digit_next = digit_reg;
        if (ctrl.clear) begin
            digit_next = '0;
        end else if (ctrl.dabble) begin
            digit_next = {adj[sbd_pkg::DIGIT_W-2:0], carry_in};
        end else if (ctrl.move) begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge aclk) begin
        digit_reg <= digit_next;
    end

    assign carry_out = adj[sbd_pkg::DIGIT_W-1];
    assign digit     = digit_reg;

endmodule

@@ src/signed_binary_to_decimal_digits_unit.sv @@
// Top level: signed binary to decimal digit converter built on a chain of BCD cells.
`timescale 1ns / 1ps

// Accepts one signed value per transfer, sign-extends its low 8/16/32/64 bits as the width
// mode says (never beyond VALUE_BITS), and returns its decimal magnitude one digit per
// result transfer, most significant digit first, with the sign on every result and last
// on the final one. A zero value gives one '0' digit; zero with zero precision gives a
// single result flagged empty_res. The most negative value is converted exactly. The
// magnitude is shifted one bit per cycle through a row of DIGITS BCD cells (double dabble);
// each item is loaded, shifted into the cells bit by bit, stripped of its leading zero digits
// (at least one digit is kept), and its digits are then handed out while the result side
// accepts them, holding while it stalls. Results wait in an output register, so a new item
// is taken as soon as the last digit of the previous one has been moved into it. s_ready is
// high only while no item is in conversion.

module signed_binary_to_decimal_digits_unit #(
    parameter int VALUE_BITS = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  sbd_pkg::sbd_in_t s_item,
    output logic             m_valid,
    input  logic             m_ready,
    output sbd_pkg::sbd_out_t m_item
);

    // Enough digits for 2^(VALUE_BITS-1); log10(2) rounded down to 0.301
    localparam int DIGITS = (VALUE_BITS * 301) / 1000 + 1;
    localparam int CNT_W  = $clog2(VALUE_BITS);
    localparam int REM_W  = $clog2(DIGITS + 1);
    localparam int KEEP_W = $clog2(VALUE_BITS + 1);

    // kept bits per mode, clipped to VALUE_BITS
    localparam int B8  = (VALUE_BITS < 8)  ? VALUE_BITS : 8;
    localparam int B16 = (VALUE_BITS < 16) ? VALUE_BITS : 16;
    localparam int B32 = (VALUE_BITS < 32) ? VALUE_BITS : 32;

    sbd_pkg::sbd_state_t state_reg, state_next;

    logic [VALUE_BITS-1:0] mag_reg, mag_next;
    logic [CNT_W-1:0]      bit_cnt_reg, bit_cnt_next;
    logic [REM_W-1:0]      rem_reg, rem_next;
    logic                  neg_reg, neg_next;
    logic                  zero_reg, zero_next;
    logic                  zp_reg, zp_next;

    logic                  m_valid_reg, m_valid_next;
    sbd_pkg::sbd_out_t     m_item_reg, m_item_next;

    // ---------------- input sign extension and magnitude ----------------
    logic [VALUE_BITS-1:0] raw;
    logic [VALUE_BITS-1:0] ext;
    logic [VALUE_BITS-1:0] mag_in;
    logic [KEEP_W-1:0]     keep_bits;
    logic                  sign_bit;

    assign raw = s_item.value[VALUE_BITS-1:0];

    always_comb begin
        unique case (s_item.width_mode)
            sbd_pkg::MODE_CHAR: begin
                keep_bits = KEEP_W'(B8);
                sign_bit  = raw[B8-1];
            end
            sbd_pkg::MODE_SHORT: begin
                keep_bits = KEEP_W'(B16);
                sign_bit  = raw[B16-1];
            end
            sbd_pkg::MODE_LONG: begin
                keep_bits = KEEP_W'(VALUE_BITS);
                sign_bit  = raw[VALUE_BITS-1];
            end
            default: begin
                keep_bits = KEEP_W'(B32);
                sign_bit  = raw[B32-1];
            end
        endcase
    end

    always_comb begin
        for (int i = 0; i < VALUE_BITS; i++) begin
            ext[i] = (KEEP_W'(i) < keep_bits) ? raw[i] : sign_bit;
        end
    end

    // two's complement negate in VALUE_BITS: -2^(n-1) comes out as 2^(n-1), exact unsigned
    assign mag_in = sign_bit ? (~ext + VALUE_BITS'(1)) : ext;

    // ---------------- cell chain ----------------
    sbd_pkg::sbd_cell_ctrl_t     cell_ctrl;
    logic [DIGITS:0]             carry;
    logic [sbd_pkg::DIGIT_W-1:0] digits [DIGITS];
    logic [sbd_pkg::DIGIT_W-1:0] top_digit;

    assign carry[0] = mag_reg[VALUE_BITS-1];

    for (genvar g = 0; g < DIGITS; g++) begin : g_cell
        logic [sbd_pkg::DIGIT_W-1:0] lower_digit;
        if (g == 0) begin : g_bottom
            assign lower_digit = '0;
        end else begin : g_upper
            assign lower_digit = digits[g-1];
        end

        sbd_digit_cell u_cell (
            .aclk      (aclk),
            .ctrl      (cell_ctrl),
            .carry_in  (carry[g]),
            .digit_in  (lower_digit),
            .carry_out (carry[g+1]),
            .digit     (digits[g])
        );
    end

    assign top_digit = digits[DIGITS-1];

    // ---------------- control ----------------
    logic load;
    logic emit;
    logic last_digit;
    logic top_zero;

    assign last_digit = (rem_reg == REM_W'(1));
    assign top_zero   = (top_digit == '0);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sbd_pkg::S_IDLE: begin
                if (s_valid) begin
                    state_next = sbd_pkg::S_CONV;
                end
            end
            sbd_pkg::S_CONV: begin
                if (bit_cnt_reg == CNT_W'(VALUE_BITS - 1)) begin
                    state_next = sbd_pkg::S_SKIP;
                end
            end
            sbd_pkg::S_SKIP: begin
                if (!top_zero || last_digit) begin
                    state_next = sbd_pkg::S_EMIT;
                end
            end
            sbd_pkg::S_EMIT: begin
                if ((!m_valid_reg || m_ready) && last_digit) begin
                    state_next = sbd_pkg::S_IDLE;
                end
            end
            default: state_next = sbd_pkg::S_IDLE;
        endcase
    end

    // outputs of the controller
    always_comb begin
        load             = 1'b0;
        emit             = 1'b0;
        cell_ctrl        = '0;
        s_ready          = 1'b0;
        unique case (state_reg)
            sbd_pkg::S_IDLE: begin
                s_ready         = 1'b1;
                load            = s_valid;
                cell_ctrl.clear = s_valid;
            end
            sbd_pkg::S_CONV: begin
                cell_ctrl.dabble = 1'b1;
            end
            sbd_pkg::S_SKIP: begin
                // drop a leading zero, keeping at least one digit
                cell_ctrl.move = top_zero && !last_digit;
            end
            sbd_pkg::S_EMIT: begin
                emit           = !m_valid_reg || m_ready;
                cell_ctrl.move = !m_valid_reg || m_ready;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // datapath next values
    always_comb begin
        mag_next     = mag_reg;
        bit_cnt_next = bit_cnt_reg;
        rem_next     = rem_reg;
        neg_next     = neg_reg;
        zero_next    = zero_reg;
        zp_next      = zp_reg;
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;

        if (load) begin
            mag_next     = mag_in;
            bit_cnt_next = '0;
            rem_next     = REM_W'(DIGITS);
            neg_next     = sign_bit;
            zero_next    = (mag_in == '0);
            zp_next      = s_item.zero_precision;
        end

        if (cell_ctrl.dabble) begin
            mag_next     = {mag_reg[VALUE_BITS-2:0], 1'b0};
            bit_cnt_next = bit_cnt_reg + CNT_W'(1);
        end

        if (cell_ctrl.move) begin
            rem_next = rem_reg - REM_W'(1);
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (emit) begin
            m_valid_next          = 1'b1;
            m_item_next.digit     = top_digit;
            m_item_next.negative  = neg_reg;
            m_item_next.empty_res = last_digit && zero_reg && zp_reg;
            m_item_next.last      = last_digit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sbd_pkg::S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload and working registers, no reset needed
    always_ff @(posedge aclk) begin
        mag_reg     <= mag_next;
        bit_cnt_reg <= bit_cnt_next;
        rem_reg     <= rem_next;
        neg_reg     <= neg_next;
        zero_reg    <= zero_next;
        zp_reg      <= zp_next;
        m_item_reg  <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

@@ src/sbd_checker.sv @@
// Port-level checker for the decimal digit unit, bound to the top level.
`timescale 1ns / 1ps

module sbd_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input sbd_pkg::sbd_out_t m_item
);

    // a stalled result transfer holds its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

    // digits are decimal
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_item.digit <= sbd_pkg::DIGIT_W'(9))
        else $error("digit out of range");

    // empty result is the lone, positive, final result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.empty_res |-> m_item.last && !m_item.negative)
        else $error("malformed empty result");

    // an accepted item occupies the converter for at least the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while converting");

endmodule

bind signed_binary_to_decimal_digits_unit sbd_checker u_sbd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);
